>>> hdl/tsac_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsac_pkg
// shared widths, register indexes and transaction types for the touch
// averaging and calibration unit
// ----------------------------------------------------------------------------
package tsac_pkg;

  localparam int RAW_W       = 12;  // converter reading
  localparam int SCR_W       = 10;  // screen coordinate
  localparam int OUT_W       = 11;  // signed result coordinate
  localparam int SUM_W       = 16;  // window sum, holds 16 readings
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 12;
  localparam int DIVN_W      = 22;  // |diff| * screen max
  localparam int DIVD_W      = 12;  // |span|
  localparam int QUEUE_DEPTH = 2;
  localparam int SAMPLES_DEF = 10;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAL_X_LOW    = 3'd0,
    REG_CAL_X_HIGH   = 3'd1,
    REG_CAL_Y_LOW    = 3'd2,
    REG_CAL_Y_HIGH   = 3'd3,
    REG_SCREEN_X_MAX = 3'd4,
    REG_SCREEN_Y_MAX = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [RAW_W-1:0] cal_x_low;
    logic [RAW_W-1:0] cal_x_high;
    logic [RAW_W-1:0] cal_y_low;
    logic [RAW_W-1:0] cal_y_high;
    logic [SCR_W-1:0] screen_x_max;
    logic [SCR_W-1:0] screen_y_max;
  } cal_cfg_t;

  // one closed window handed from front to back
  typedef struct packed {
    logic             good;
    logic [SUM_W-1:0] sum_x;
    logic [SUM_W-1:0] sum_y;
  } job_t;

  // divider handshake toward the sequencer
  typedef struct packed {
    logic              done;
    logic [DIVN_W-1:0] quot;
  } div_res_t;

endpackage

>>> hdl/touch_sample_average_calibrate_unit.sv
`timescale 1ns / 1ps
// throughput: one transaction per cycle into the accumulator, held off only when a
//   window closes with the queue full; a counted window holds the back end through up to two
//   divides, and a two-window queue lets the front run ahead
// reset: rst_n synchronous active low; clears sums, counters, queue and
//   sequencer, and loads the calibration registers with their defaults
// ----------------------------------------------------------------------------
// touch_sample_average_calibrate_unit
// averages raw touch conversion pairs over a window and maps the averages
// to screen coordinates through the calibration registers
// ----------------------------------------------------------------------------
module touch_sample_average_calibrate_unit import tsac_pkg::*; #(
  parameter int SAMPLES = SAMPLES_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // configuration writes
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata,
  // input transactions
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_pen_before_x,
  input  logic [RAW_W-1:0]        in_raw_x,
  input  logic                    in_pen_before_y,
  input  logic [RAW_W-1:0]        in_raw_y,
  // result transactions
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    out_touch_valid,
  output logic signed [OUT_W-1:0] out_screen_x,
  output logic signed [OUT_W-1:0] out_screen_y
);

  cal_cfg_t cfg_r;
  logic     push, q_full, pop, q_valid;
  job_t     push_job, q_job;

  // calibration register file, indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cal_x_low    <= RAW_W'(0);
      cfg_r.cal_x_high   <= RAW_W'(4095);
      cfg_r.cal_y_low    <= RAW_W'(0);
      cfg_r.cal_y_high   <= RAW_W'(4095);
      cfg_r.screen_x_max <= SCR_W'(319);
      cfg_r.screen_y_max <= SCR_W'(239);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CAL_X_LOW:    cfg_r.cal_x_low    <= cfg_wdata[RAW_W-1:0];
        REG_CAL_X_HIGH:   cfg_r.cal_x_high   <= cfg_wdata[RAW_W-1:0];
        REG_CAL_Y_LOW:    cfg_r.cal_y_low    <= cfg_wdata[RAW_W-1:0];
        REG_CAL_Y_HIGH:   cfg_r.cal_y_high   <= cfg_wdata[RAW_W-1:0];
        REG_SCREEN_X_MAX: cfg_r.screen_x_max <= cfg_wdata[SCR_W-1:0];
        REG_SCREEN_Y_MAX: cfg_r.screen_y_max <= cfg_wdata[SCR_W-1:0];
        default: ;
      endcase
    end
  end

  // front: qualify pairs and sum one window, hand closed windows on
  tsac_front #(.SAMPLES(SAMPLES)) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_pen_before_x (in_pen_before_x),
    .in_raw_x        (in_raw_x),
    .in_pen_before_y (in_pen_before_y),
    .in_raw_y        (in_raw_y),
    .push            (push),
    .push_job        (push_job),
    .q_full          (q_full)
  );

  // closed windows wait here so the front keeps taking transactions
  tsac_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_job    (q_job)
  );

  // back: average, calibrate, clamp and present the result
  tsac_back #(.SAMPLES(SAMPLES)) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .q_valid         (q_valid),
    .q_job           (q_job),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_touch_valid (out_touch_valid),
    .out_screen_x    (out_screen_x),
    .out_screen_y    (out_screen_y)
  );

endmodule

>>> hdl/tsac_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsac_front
// accepts conversion pairs, qualifies them and accumulates one window
// ----------------------------------------------------------------------------
module tsac_front import tsac_pkg::*; #(
  parameter int SAMPLES = SAMPLES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_pen_before_x,
  input  logic [RAW_W-1:0] in_raw_x,
  input  logic             in_pen_before_y,
  input  logic [RAW_W-1:0] in_raw_y,
  output logic             push,
  output job_t             push_job,
  input  logic             q_full
);

  localparam int POS_W = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;

  logic [POS_W-1:0] pos_r;
  logic [SUM_W-1:0] sum_x_r, sum_y_r;
  logic             all_good_r;
  logic             counted, closing, accept;
  logic [SUM_W-1:0] sum_x_nxt, sum_y_nxt;

  assign counted = in_pen_before_x && in_pen_before_y &&
                   (in_raw_x != '0) && (in_raw_y != '0);
  assign closing = (pos_r == POS_W'(SAMPLES - 1));
  assign in_ready = !closing || !q_full;
  assign accept   = in_valid && in_ready;

  assign sum_x_nxt = sum_x_r + (counted ? SUM_W'(in_raw_x) : '0);
  assign sum_y_nxt = sum_y_r + (counted ? SUM_W'(in_raw_y) : '0);

  assign push           = accept && closing;
  assign push_job.good  = all_good_r && counted;
  assign push_job.sum_x = sum_x_nxt;
  assign push_job.sum_y = sum_y_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      sum_x_r    <= '0;
      sum_y_r    <= '0;
      all_good_r <= 1'b1;
    end else if (accept) begin
      if (closing) begin
        pos_r      <= '0;
        sum_x_r    <= '0;
        sum_y_r    <= '0;
        all_good_r <= 1'b1;
      end else begin
        pos_r      <= pos_r + 1'b1;
        sum_x_r    <= sum_x_nxt;
        sum_y_r    <= sum_y_nxt;
        all_good_r <= all_good_r && counted;
      end
    end
  end

endmodule

>>> hdl/tsac_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsac_queue
// short fifo of closed windows between front and back
// ----------------------------------------------------------------------------
module tsac_queue import tsac_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic q_valid,
  output job_t q_job
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             entries_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full    = (count_r == CNT_W'(QUEUE_DEPTH));
  assign q_valid = (count_r != '0);
  assign q_job   = entries_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

>>> hdl/tsac_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsac_div
// unsigned restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module tsac_div import tsac_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIVN_W-1:0] dividend,
  input  logic [DIVD_W-1:0] divisor,
  output div_res_t          res
);

  localparam int CNT_W = $clog2(DIVN_W + 1);

  logic [DIVN_W-1:0] a_r;
  logic [DIVD_W-1:0] b_r;
  logic [DIVD_W-1:0] rem_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r, done_r;
  logic [DIVD_W:0]   rem_sh;
  logic              qbit;

  assign rem_sh = {rem_r, a_r[DIVN_W-1]};
  assign qbit   = (rem_sh >= {1'b0, b_r});

  assign res.done = done_r;
  assign res.quot = a_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DIVN_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= dividend;
      b_r   <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      a_r   <= {a_r[DIVN_W-2:0], qbit};
      rem_r <= qbit ? DIVD_W'(rem_sh - {1'b0, b_r}) : rem_sh[DIVD_W-1:0];
    end
  end

endmodule

>>> hdl/tsac_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsac_back
// per-window sequencer: averages, calibration multiply, divide, clamp and
// the output register
// ----------------------------------------------------------------------------
module tsac_back import tsac_pkg::*; #(
  parameter int SAMPLES = SAMPLES_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cal_cfg_t                cfg,
  input  logic                    q_valid,
  input  job_t                    q_job,
  output logic                    pop,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    out_touch_valid,
  output logic signed [OUT_W-1:0] out_screen_x,
  output logic signed [OUT_W-1:0] out_screen_y
);

  localparam int DIFF_W = RAW_W + 1;
  localparam int WIDE_W = DIVN_W + 3;
  // window average as a reciprocal multiply, exact for any 16-bit sum
  localparam int AVG_SH = SUM_W + 4;
  localparam int AVG_W  = AVG_SH + 1;
  localparam int PROD_W = SUM_W + AVG_W;
  localparam logic [AVG_W-1:0] AVG_MUL = AVG_W'(((1 << AVG_SH) + SAMPLES - 1) / SAMPLES);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL_X, S_DIV_X, S_MUL_Y, S_DIV_Y, S_EMIT
  } state_t;

  state_t            state_r;
  logic              good_r;
  logic [RAW_W-1:0]  avg_x_r, avg_y_r;
  logic [SCR_W-1:0]  res_x_r, res_y_r;
  logic              neg_r;
  logic              div_start_r;
  logic [DIVN_W-1:0] div_a_r;
  logic [DIVD_W-1:0] div_b_r;
  div_res_t          div_res;

  logic              out_valid_r, out_touch_valid_r;
  logic [OUT_W-1:0]  out_x_r, out_y_r;

  logic [PROD_W-1:0] avg_x_prod, avg_y_prod;

  // calibration datapath, selected per axis
  logic                     axis_y;
  logic [RAW_W-1:0]         avg_sel, lo_sel, hi_sel;
  logic [SCR_W-1:0]         smax_sel;
  logic signed [DIFF_W-1:0] diff, span;
  logic [RAW_W-1:0]         diff_mag, span_mag;
  logic [DIVN_W-1:0]        prod;
  logic signed [WIDE_W-1:0] q_ext, q_sgn, v, smax_ext;
  logic [SCR_W-1:0]         clamped;

  assign avg_x_prod = PROD_W'(q_job.sum_x) * PROD_W'(AVG_MUL);
  assign avg_y_prod = PROD_W'(q_job.sum_y) * PROD_W'(AVG_MUL);

  assign axis_y   = (state_r == S_MUL_Y) || (state_r == S_DIV_Y);
  assign avg_sel  = axis_y ? avg_y_r : avg_x_r;
  assign lo_sel   = axis_y ? cfg.cal_y_low : cfg.cal_x_low;
  assign hi_sel   = axis_y ? cfg.cal_y_high : cfg.cal_x_high;
  assign smax_sel = axis_y ? cfg.screen_y_max : cfg.screen_x_max;

  always_comb begin
    diff     = $signed({1'b0, avg_sel}) - $signed({1'b0, lo_sel});
    span     = $signed({1'b0, hi_sel}) - $signed({1'b0, lo_sel});
    diff_mag = diff[DIFF_W-1] ? RAW_W'(-diff) : diff[RAW_W-1:0];
    span_mag = span[DIFF_W-1] ? RAW_W'(-span) : span[RAW_W-1:0];
    prod     = DIVN_W'(diff_mag) * DIVN_W'(smax_sel);
    // truncation toward zero: divide magnitudes, then apply the sign
    q_ext    = $signed({3'b000, div_res.quot});
    q_sgn    = neg_r ? -q_ext : q_ext;
    smax_ext = $signed({{(WIDE_W - SCR_W){1'b0}}, smax_sel});
    // first axis runs inverted: smax - quotient
    v        = axis_y ? q_sgn : smax_ext - q_sgn;
    if (v < 0) begin
      clamped = '0;
    end else if (v > smax_ext) begin
      clamped = smax_sel;
    end else begin
      clamped = v[SCR_W-1:0];
    end
  end

  tsac_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start_r),
    .dividend (div_a_r),
    .divisor  (div_b_r),
    .res      (div_res)
  );

  assign pop             = (state_r == S_IDLE) && q_valid;
  assign out_valid       = out_valid_r;
  assign out_touch_valid = out_touch_valid_r;
  assign out_screen_x    = $signed(out_x_r);
  assign out_screen_y    = $signed(out_y_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      div_start_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      div_start_r <= 1'b0;
      if ((state_r == S_EMIT) && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            good_r <= q_job.good;
            if (q_job.good) begin
              avg_x_r <= avg_x_prod[AVG_SH +: RAW_W];
              avg_y_r <= avg_y_prod[AVG_SH +: RAW_W];
              state_r <= S_MUL_X;
            end else begin
              state_r <= S_EMIT;
            end
          end
        end
        S_MUL_X: begin
          if (span == 0) begin
            res_x_r <= '0;
            state_r <= S_MUL_Y;
          end else begin
            div_a_r     <= prod;
            div_b_r     <= span_mag;
            neg_r       <= diff[DIFF_W-1] ^ span[DIFF_W-1];
            div_start_r <= 1'b1;
            state_r     <= S_DIV_X;
          end
        end
        S_DIV_X: begin
          if (div_res.done) begin
            res_x_r <= clamped;
            state_r <= S_MUL_Y;
          end
        end
        S_MUL_Y: begin
          if (span == 0) begin
            res_y_r <= '0;
            state_r <= S_EMIT;
          end else begin
            div_a_r     <= prod;
            div_b_r     <= span_mag;
            neg_r       <= diff[DIFF_W-1] ^ span[DIFF_W-1];
            div_start_r <= 1'b1;
            state_r     <= S_DIV_Y;
          end
        end
        S_DIV_Y: begin
          if (div_res.done) begin
            res_y_r <= clamped;
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_valid_r || out_ready) begin
            out_touch_valid_r <= good_r;
            out_x_r           <= good_r ? {1'b0, res_x_r} : '1;
            out_y_r           <= good_r ? {1'b0, res_y_r} : '1;
            state_r           <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
